// ===== hdl/dfir_pkg.sv =====
// dfir_pkg: shared types and constants for the decimating fir filter
// register indexes, field widths, default sizes and control bundles
// no dependencies
`default_nettype none

package dfir_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned DEF_MAX_TAPS     = 128;
  localparam int unsigned DEF_SAMPLE_WIDTH = 16;
  localparam int unsigned DEF_COEF_WIDTH   = 16;

  // fixed field and register widths
  localparam int unsigned TAP_IDX_W  = 7;
  localparam int unsigned DECIM_W    = 9;
  localparam int unsigned TAPS_W     = 8;
  localparam int unsigned PHASE_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned MAX_DECIM  = 256;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECIM = 2'd0,
    CFG_TAPS  = 2'd1,
    CFG_CPLX  = 2'd2
  } cfg_reg_e;

  // item kind carried on tuser
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TAP    = 1'b1
  } op_e;

  // controls broadcast to every history cell
  typedef struct packed {
    logic shift;  // new sample enters the history chain
    logic load;   // window copy takes the shifted history
    logic step;   // window moves one cell toward the head
  } cell_ctl_t;

  // per-tap controls into the multiply-accumulate unit
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/dfir_cell.sv =====
// dfir_cell: one history cell holding an i/q sample and its window copy
// depends on dfir_pkg (cell_ctl_t)
`default_nettype none

module dfir_cell #(
  parameter int unsigned SAMPLE_WIDTH = dfir_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                           clk_i,
  input  dfir_pkg::cell_ctl_t            ctl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] hist_in_i_i,  // from the newer neighbor
  input  logic signed [SAMPLE_WIDTH-1:0] hist_in_q_i,
  input  logic signed [SAMPLE_WIDTH-1:0] win_in_i_i,   // from the older neighbor
  input  logic signed [SAMPLE_WIDTH-1:0] win_in_q_i,
  output logic signed [SAMPLE_WIDTH-1:0] hist_i_o,
  output logic signed [SAMPLE_WIDTH-1:0] hist_q_o,
  output logic signed [SAMPLE_WIDTH-1:0] win_i_o,
  output logic signed [SAMPLE_WIDTH-1:0] win_q_o
);

  logic signed [SAMPLE_WIDTH-1:0] hist_i_q, hist_i_d;
  logic signed [SAMPLE_WIDTH-1:0] hist_q_q, hist_q_d;
  logic signed [SAMPLE_WIDTH-1:0] win_i_q, win_i_d;
  logic signed [SAMPLE_WIDTH-1:0] win_q_q, win_q_d;

  always_comb begin
    hist_i_d = hist_i_q;
    hist_q_d = hist_q_q;
    win_i_d  = win_i_q;
    win_q_d  = win_q_q;
    if (ctl_i.shift) begin
      hist_i_d = hist_in_i_i;
      hist_q_d = hist_in_q_i;
    end
    if (ctl_i.load) begin
      win_i_d = hist_in_i_i;
      win_q_d = hist_in_q_i;
    end else if (ctl_i.step) begin
      win_i_d = win_in_i_i;
      win_q_d = win_in_q_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hist_i_q <= hist_i_d;
    hist_q_q <= hist_q_d;
    win_i_q  <= win_i_d;
    win_q_q  <= win_q_d;
  end

  assign hist_i_o = hist_i_q;
  assign hist_q_o = hist_q_q;
  assign win_i_o  = win_i_q;
  assign win_q_o  = win_q_q;

endmodule

`default_nettype wire

// ===== hdl/dfir_tap_mem.sv =====
// dfir_tap_mem: coefficient store, one write and one registered read port
// entries read as zero until written; no package dependencies
`default_nettype none

module dfir_tap_mem #(
  parameter  int unsigned DEPTH = 128,
  parameter  int unsigned WIDTH = 16,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    we_i,
  input  logic [AW-1:0]           waddr_i,
  input  logic signed [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]           raddr_i,
  output logic signed [WIDTH-1:0] rdata_o
);

  logic signed [WIDTH-1:0] mem_q [DEPTH];
  logic signed [WIDTH-1:0] raw_q;
  logic [DEPTH-1:0]        vld_q;
  logic                    rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    raw_q <= mem_q[raddr_i];
  end

  // per-entry written flags stand in for the all-zero reset contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? raw_q : '0;

endmodule

`default_nettype wire

// ===== hdl/dfir_mac.sv =====
// dfir_mac: shared multiply-accumulate for the i and q rails
// one tap per cycle, registered product, running sum; depends on dfir_pkg
`default_nettype none

module dfir_mac #(
  parameter int unsigned SAMPLE_WIDTH = dfir_pkg::DEF_SAMPLE_WIDTH,
  parameter int unsigned COEF_WIDTH   = dfir_pkg::DEF_COEF_WIDTH,
  parameter int unsigned ACC_W        = 39
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dfir_pkg::mac_ctl_t             ctl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] smp_i_i,
  input  logic signed [SAMPLE_WIDTH-1:0] smp_q_i,
  input  logic signed [COEF_WIDTH-1:0]   tap_i,     // arrives in the cycle after ctl_i
  output logic signed [ACC_W-1:0]        acc_i_o,
  output logic signed [ACC_W-1:0]        acc_q_o,
  output logic                           done_o,
  output logic                           busy_o
);

  localparam int unsigned PROD_W = SAMPLE_WIDTH + COEF_WIDTH;

  dfir_pkg::mac_ctl_t ctl1_q, ctl2_q;
  logic                           done_q;
  logic signed [SAMPLE_WIDTH-1:0] smp1_i_q, smp1_q_q;
  logic signed [PROD_W-1:0]       prod_i_d, prod_q_d;
  logic signed [PROD_W-1:0]       prod_i_q, prod_q_q;
  logic signed [ACC_W-1:0]        acc_i_d, acc_q_d;
  logic signed [ACC_W-1:0]        acc_i_q, acc_q_q;

  assign prod_i_d = tap_i * smp1_i_q;
  assign prod_q_d = tap_i * smp1_q_q;

  always_comb begin
    acc_i_d = acc_i_q;
    acc_q_d = acc_q_q;
    if (ctl2_q.valid) begin
      if (ctl2_q.first) begin
        acc_i_d = ACC_W'(prod_i_q);
        acc_q_d = ACC_W'(prod_q_q);
      end else begin
        acc_i_d = acc_i_q + ACC_W'(prod_i_q);
        acc_q_d = acc_q_q + ACC_W'(prod_q_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      done_q <= ctl2_q.valid & ctl2_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    smp1_i_q <= smp_i_i;
    smp1_q_q <= smp_q_i;
    prod_i_q <= prod_i_d;
    prod_q_q <= prod_q_d;
    acc_i_q  <= acc_i_d;
    acc_q_q  <= acc_q_d;
  end

  assign acc_i_o = acc_i_q;
  assign acc_q_o = acc_q_q;
  assign done_o  = done_q;
  assign busy_o  = ctl1_q.valid | ctl2_q.valid | done_q;

endmodule

`default_nettype wire

// ===== hdl/decimating_fir_filter_top.sv =====
// decimating_fir_filter_top: decimating fir filter over i/q or real samples
// depends on dfir_pkg, dfir_cell, dfir_tap_mem, dfir_mac
//
//   channel   direction  contents
//   s_axis    in         tuser: op; tdata: sample_i, sample_q, tap_index, tap_value
//   m_axis    out        tdata: out_i, out_q
//   cfg       in         write enable, register index, write data (no read-back)
//
// a tap load or a sample that produces no output does not hold off input
// a sample that produces an output holds off input until its sums leave the first
// finishing stage: the shared multiply-accumulate walks the window of L taps
// one tap per cycle (L is the tap count), then two finishing stages truncate and saturate the sums
// the output register lets one result wait for m_axis_tready while input resumes
// asynchronous active-low reset clears counters, tap flags and handshakes and restores the configuration defaults
`default_nettype none

module decimating_fir_filter_top #(
  parameter  int unsigned MAX_TAPS     = dfir_pkg::DEF_MAX_TAPS,
  parameter  int unsigned SAMPLE_WIDTH = dfir_pkg::DEF_SAMPLE_WIDTH,
  parameter  int unsigned COEF_WIDTH   = dfir_pkg::DEF_COEF_WIDTH,
  localparam int unsigned IN_TDATA_W   =
    ((2 * SAMPLE_WIDTH + dfir_pkg::TAP_IDX_W + COEF_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_TDATA_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [IN_TDATA_W-1:0]           s_axis_tdata,  // sample_i, sample_q, tap_index,
                                                         // tap_value, zero fill
  input  logic                            s_axis_tuser,  // op
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [OUT_TDATA_W-1:0]          m_axis_tdata,  // out_i, out_q, zero fill
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [dfir_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dfir_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned TAP_AW  = $clog2(MAX_TAPS);
  localparam int unsigned CNT_W   = $clog2(MAX_TAPS + 1);
  localparam int unsigned ACC_W   = SAMPLE_WIDTH + COEF_WIDTH + $clog2(MAX_TAPS);
  localparam int unsigned OFF_IDX = 2 * SAMPLE_WIDTH;
  localparam int unsigned OFF_TAP = OFF_IDX + dfir_pkg::TAP_IDX_W;
  localparam int unsigned DECIM_W = dfir_pkg::DECIM_W;
  localparam int unsigned PHASE_W = dfir_pkg::PHASE_W;

  // saturation bounds on the shifted magnitude
  localparam logic [ACC_W-1:0] SAT_LIM = ACC_W'(1) << (SAMPLE_WIDTH - 1);
  localparam logic [ACC_W-1:0] SAT_POS = SAT_LIM - ACC_W'(1);

  // ---------------------------------------------------------------------------
  // input field unpacking
  // ---------------------------------------------------------------------------
  logic                                 in_op;
  logic signed [SAMPLE_WIDTH-1:0]       in_smp_i, in_smp_q;
  logic [dfir_pkg::TAP_IDX_W-1:0]       in_tap_idx;
  logic signed [COEF_WIDTH-1:0]         in_tap_val;

  assign in_op      = s_axis_tuser;
  assign in_smp_i   = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign in_smp_q   = s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
  assign in_tap_idx = s_axis_tdata[OFF_IDX +: dfir_pkg::TAP_IDX_W];
  assign in_tap_val = s_axis_tdata[OFF_TAP +: COEF_WIDTH];

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [DECIM_W-1:0]          decim_q;
  logic [dfir_pkg::TAPS_W-1:0] taps_q;
  logic                        cplx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decim_q <= DECIM_W'(1);
      taps_q  <= dfir_pkg::TAPS_W'(1);
      cplx_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dfir_pkg::CFG_DECIM: decim_q <= cfg_data_i[DECIM_W-1:0];
        dfir_pkg::CFG_TAPS:  taps_q  <= cfg_data_i[dfir_pkg::TAPS_W-1:0];
        dfir_pkg::CFG_CPLX:  cplx_q  <= cfg_data_i[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // clamp decimation factor to 1..256 and tap count to 1..MAX_TAPS
  logic [DECIM_W-1:0] m_eff;
  logic [CNT_W-1:0]   len_eff;

  always_comb begin
    if (decim_q == '0) begin
      m_eff = DECIM_W'(1);
    end else if (decim_q > DECIM_W'(dfir_pkg::MAX_DECIM)) begin
      m_eff = DECIM_W'(dfir_pkg::MAX_DECIM);
    end else begin
      m_eff = decim_q;
    end
    if (taps_q == '0) begin
      len_eff = CNT_W'(1);
    end else if (32'(taps_q) > MAX_TAPS) begin
      len_eff = CNT_W'(MAX_TAPS);
    end else begin
      len_eff = CNT_W'(taps_q);
    end
  end

  // ---------------------------------------------------------------------------
  // input acceptance and sample counters
  // ---------------------------------------------------------------------------
  logic mac_busy, mac_done;
  logic pass_q, pass_d;
  logic fin_vld_q, fin_vld_d;
  logic busy, in_fire, smp_fire, tap_fire, emit, win_full, pass_last;

  logic [CNT_W-1:0]   fill_q, fill_d, fill_nx;
  logic [PHASE_W-1:0] phase_q, phase_d, phase_wrap;
  logic [DECIM_W-1:0] phase_nx;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // one item in flight: input waits while a window pass or its result is pending
  assign busy          = pass_q | mac_busy | fin_vld_q;
  assign s_axis_tready = !busy;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign smp_fire      = in_fire & (in_op == dfir_pkg::OP_SAMPLE);
  assign tap_fire      = in_fire & (in_op == dfir_pkg::OP_TAP)
                       & (32'(in_tap_idx) < MAX_TAPS);

  // fill count saturates at the history depth
  assign fill_nx  = (fill_q < CNT_W'(MAX_TAPS)) ? fill_q + CNT_W'(1) : fill_q;
  assign win_full = fill_nx >= len_eff;

  // phase only advances once the window has filled
  assign phase_nx   = DECIM_W'(phase_q) + DECIM_W'(1);
  assign phase_wrap = (phase_nx >= m_eff) ? '0 : phase_nx[PHASE_W-1:0];
  assign emit       = smp_fire & win_full & (phase_q == '0);

  assign fill_d  = smp_fire ? fill_nx : fill_q;
  assign phase_d = (smp_fire & win_full) ? phase_wrap : phase_q;

  // ---------------------------------------------------------------------------
  // window pass: one tap per cycle, newest sample paired with tap L-1
  // ---------------------------------------------------------------------------
  assign pass_last = (cnt_q == len_eff - CNT_W'(1));

  always_comb begin
    pass_d = pass_q;
    cnt_d  = cnt_q;
    if (emit) begin
      pass_d = 1'b1;
      cnt_d  = '0;
    end else if (pass_q) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (pass_last) begin
        pass_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      phase_q <= '0;
      pass_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      fill_q  <= fill_d;
      phase_q <= phase_d;
      pass_q  <= pass_d;
      cnt_q   <= cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // history chain: cell 0 holds the newest sample
  // ---------------------------------------------------------------------------
  dfir_pkg::cell_ctl_t cell_ctl;

  logic signed [SAMPLE_WIDTH-1:0] hist_i_w [MAX_TAPS+1];
  logic signed [SAMPLE_WIDTH-1:0] hist_q_w [MAX_TAPS+1];
  logic signed [SAMPLE_WIDTH-1:0] win_i_w  [MAX_TAPS+1];
  logic signed [SAMPLE_WIDTH-1:0] win_q_w  [MAX_TAPS+1];

  assign cell_ctl.shift = smp_fire;
  assign cell_ctl.load  = emit;     // window snapshot includes the arriving sample
  assign cell_ctl.step  = pass_q;   // window drains toward cell 0

  assign hist_i_w[0]       = in_smp_i;
  assign hist_q_w[0]       = in_smp_q;
  assign win_i_w[MAX_TAPS] = '0;
  assign win_q_w[MAX_TAPS] = '0;

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    dfir_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (cell_ctl),
      .hist_in_i_i(hist_i_w[j]),
      .hist_in_q_i(hist_q_w[j]),
      .win_in_i_i (win_i_w[j+1]),
      .win_in_q_i (win_q_w[j+1]),
      .hist_i_o   (hist_i_w[j+1]),
      .hist_q_o   (hist_q_w[j+1]),
      .win_i_o    (win_i_w[j]),
      .win_q_o    (win_q_w[j])
    );
  end

  // ---------------------------------------------------------------------------
  // coefficient store, read in step with the window pass
  // ---------------------------------------------------------------------------
  logic [TAP_AW-1:0]            tap_raddr;
  logic signed [COEF_WIDTH-1:0] tap_rd;

  assign tap_raddr = TAP_AW'(len_eff - CNT_W'(1) - cnt_q);

  dfir_tap_mem #(
    .DEPTH(MAX_TAPS),
    .WIDTH(COEF_WIDTH)
  ) u_tap_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (tap_fire),
    .waddr_i(TAP_AW'(in_tap_idx)),
    .wdata_i(in_tap_val),
    .raddr_i(tap_raddr),
    .rdata_o(tap_rd)
  );

  // ---------------------------------------------------------------------------
  // multiply-accumulate
  // ---------------------------------------------------------------------------
  dfir_pkg::mac_ctl_t      mac_ctl;
  logic signed [ACC_W-1:0] acc_i, acc_q;

  assign mac_ctl.valid = pass_q;
  assign mac_ctl.first = (cnt_q == '0);
  assign mac_ctl.last  = pass_last;

  dfir_mac #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH),
    .ACC_W       (ACC_W)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .smp_i_i(win_i_w[0]),
    .smp_q_i(win_q_w[0]),
    .tap_i  (tap_rd),
    .acc_i_o(acc_i),
    .acc_q_o(acc_q),
    .done_o (mac_done),
    .busy_o (mac_busy)
  );

  // ---------------------------------------------------------------------------
  // finishing: sign/magnitude, then shift by COEF_WIDTH-1 and saturate
  // ---------------------------------------------------------------------------
  logic             fin_neg_i_q, fin_neg_q_q;
  logic [ACC_W-1:0] fin_mag_i_q, fin_mag_q_q;
  logic             out_free;
  logic             out_vld_q, out_vld_d;
  logic [SAMPLE_WIDTH-1:0] out_i_q, out_q_q;
  logic [SAMPLE_WIDTH-1:0] sat_i, sat_q;

  // truncation toward zero: shift the magnitude, restore the sign afterward
  function automatic logic [SAMPLE_WIDTH-1:0] sat_shift(input logic             neg,
                                                        input logic [ACC_W-1:0] mag);
    logic [ACC_W-1:0] shr;
    logic [ACC_W-1:0] negd;
    shr  = mag >> (COEF_WIDTH - 1);
    negd = ~shr + ACC_W'(1);
    if (!neg) begin
      return (shr > SAT_POS) ? SAT_POS[SAMPLE_WIDTH-1:0] : shr[SAMPLE_WIDTH-1:0];
    end
    return (shr > SAT_LIM) ? SAT_LIM[SAMPLE_WIDTH-1:0] : negd[SAMPLE_WIDTH-1:0];
  endfunction

  assign sat_i    = sat_shift(fin_neg_i_q, fin_mag_i_q);
  assign sat_q    = cplx_q ? sat_shift(fin_neg_q_q, fin_mag_q_q) : '0;
  assign out_free = !out_vld_q | m_axis_tready;

  always_comb begin
    fin_vld_d = fin_vld_q;
    if (mac_done) begin
      fin_vld_d = 1'b1;
    end else if (fin_vld_q & out_free) begin
      fin_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (fin_vld_q & out_free) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      fin_vld_q <= fin_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mac_done) begin
      fin_neg_i_q <= acc_i[ACC_W-1];
      fin_neg_q_q <= acc_q[ACC_W-1];
      fin_mag_i_q <= acc_i[ACC_W-1] ? ~acc_i + ACC_W'(1) : acc_i;
      fin_mag_q_q <= acc_q[ACC_W-1] ? ~acc_q + ACC_W'(1) : acc_q;
    end
    if (fin_vld_q & out_free) begin
      out_i_q <= sat_i;
      out_q_q <= sat_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_q_q, out_i_q});

`ifndef SYNTHESIS
  // a window pass starts only from an accepted sample that completes a window
  a_pass_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pass_q) |-> $past(emit))
    else $error("window pass started without an emitting sample");

  // a finished sum never lands on a result still waiting in the finish stage
  a_done_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> !fin_vld_q)
    else $error("accumulator result overwrote pending result");

  // no pass runs while a result waits for the output register
  a_fin_no_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_vld_q |-> !pass_q)
    else $error("window pass overlaps pending result");

  // fill count saturates at the history depth
  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_fire |=> (fill_q <= CNT_W'(MAX_TAPS)))
    else $error("fill count beyond history depth");
`endif

endmodule

`default_nettype wire
